// ===== rtl/ede_pkg.sv =====
// Shared types, sizes and helpers for the edit distance engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ede_pkg;

    localparam int MAX_QUERY     = 16;
    localparam int MAX_CANDIDATE = 255;

    localparam int DIST_W  = 8;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 5;
    localparam int CFG_W   = 64;
    localparam int CIDX_W  = 2;
    localparam int POS_W   = $clog2(MAX_QUERY + 1);
    localparam int CNT_W   = $clog2(MAX_CANDIDATE + 1);
    localparam int BYTES_PER_REG = CFG_W / CHAR_W;

    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [POS_W-1:0]  t_pos;

    localparam t_dist DIST_MAX = '1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_QUERY_LEN  = 2'd0,
        CFG_CHARS_LOW  = 2'd1,
        CFG_CHARS_HIGH = 2'd2
    } t_cfg_reg;

    // One character travelling down the row of cells.
    typedef struct packed {
        logic  valid;
        t_char ch;
        logic  proc;      // character updates the column
        logic  last;
        logic  too_long;
        t_dist left_new;  // updated entry of the previous cell
        t_dist left_old;  // entry of the previous cell before the update
        t_dist result;    // entry picked by the query length
    } t_token;

    function automatic t_dist sat_inc(t_dist v);
        return (v == DIST_MAX) ? v : v + t_dist'(1);
    endfunction

    function automatic t_dist min3(t_dist a, t_dist b, t_dist c);
        t_dist m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

endpackage

// ===== rtl/ede_front.sv =====
// Head cell of the row: counts candidate characters (column entry 0),
// flags words that are too long and launches each item into the row.
// Depends on ede_pkg.
`timescale 1ns / 1ps

module ede_front
    import ede_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_accept,
    input  t_char  i_char,
    input  logic   i_has_char,
    input  logic   i_last,
    input  logic   i_sel,
    output t_token o_tok
);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_too_long, n_too_long;
    t_dist            r_dp0, n_dp0;
    t_token           r_tok, n_tok;

    logic  w_full;
    logic  w_proc;
    t_dist w_new;

    always_comb begin
        w_full = (r_count >= CNT_W'(MAX_CANDIDATE));
        w_proc = i_has_char & ~w_full;
        w_new  = w_proc ? sat_inc(r_dp0) : r_dp0;

        n_tok.valid    = i_accept;
        n_tok.ch       = i_char;
        n_tok.proc     = w_proc;
        n_tok.last     = i_last;
        n_tok.too_long = r_too_long | (i_has_char & w_full);
        n_tok.left_new = w_new;
        n_tok.left_old = r_dp0;
        // keep result from entry 0 only when the query is empty
        n_tok.result   = i_sel ? w_new : '0;

        n_count    = r_count;
        n_too_long = r_too_long;
        n_dp0      = r_dp0;
        if (i_accept) begin
            if (i_last) begin
                // restart the column for the next word
                n_count    = '0;
                n_too_long = 1'b0;
                n_dp0      = '0;
            end else begin
                n_count    = w_proc ? r_count + CNT_W'(1) : r_count;
                n_too_long = n_tok.too_long;
                n_dp0      = w_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_too_long <= 1'b0;
            r_dp0      <= '0;
            r_tok      <= '0;
        end else if (i_adv) begin
            r_count    <= n_count;
            r_too_long <= n_too_long;
            r_dp0      <= n_dp0;
            r_tok      <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/ede_cell.sv =====
// One query position of the row: holds its column entry and updates it
// as each candidate character passes by, one cell per cycle while the row is not stalled.
// Depends on ede_pkg.
`timescale 1ns / 1ps

module ede_cell
    import ede_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_char  i_qchar,
    input  t_dist  i_init,
    input  logic   i_sel,
    input  t_token i_tok,
    output t_token o_tok
);

    t_dist  r_dp, n_dp;
    t_token r_tok, n_tok;

    t_dist w_sub;
    t_dist w_new;

    always_comb begin
        w_sub = (i_qchar == i_tok.ch) ? i_tok.left_old : sat_inc(i_tok.left_old);
        w_new = i_tok.proc ? min3(sat_inc(i_tok.left_new), sat_inc(r_dp), w_sub) : r_dp;

        n_tok          = i_tok;
        n_tok.left_new = w_new;
        n_tok.left_old = r_dp;
        n_tok.result   = (i_sel && i_tok.last) ? w_new : i_tok.result;

        n_dp = r_dp;
        if (i_tok.valid) begin
            // drop back to the start value once the word has passed
            n_dp = i_tok.last ? i_init : w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp  <= i_init;
            r_tok <= '0;
        end else if (i_adv) begin
            r_dp  <= n_dp;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/edit_distance_engine.sv =====
// Levenshtein distance engine: a row of MAX_QUERY cells, one per query position.
// A last-marked item passes through the head cell register, then one register
// per query cell, then the output register, which offers its result.
// Throughput: one character per cycle while the row shifts, which it does
// whenever the output register is empty or being taken. Synchronous active-low
// reset restores every column entry to its position and clears query registers
// to zero.
`timescale 1ns / 1ps

module edit_distance_engine
    import ede_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // candidate characters
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // [7:0] cand_char
    input  logic [0:0]        i_s_axis_tuser,   // [0] has_char
    input  logic              i_s_axis_tlast,   // last
    // distances
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,   // [7:0] distance
    output logic [0:0]        o_m_axis_tuser    // [0] overflow
);

    logic [LEN_W-1:0] r_len;
    logic [CFG_W-1:0] r_qlo;
    logic [CFG_W-1:0] r_qhi;

    logic   w_adv;
    logic   w_accept;
    t_pos   w_m;
    t_token w_tok [0:MAX_QUERY];

    logic  r_out_valid;
    t_dist r_out_dist;
    logic  r_out_ovf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_qlo <= '0;
            r_qhi <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_QUERY_LEN:  r_len <= i_cfg_data[LEN_W-1:0];
                CFG_CHARS_LOW:  r_qlo <= i_cfg_data;
                CFG_CHARS_HIGH: r_qhi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(r_len) > MAX_QUERY) begin
            w_m = POS_W'(MAX_QUERY);
        end else begin
            w_m = POS_W'(r_len);
        end
    end

    assign w_adv           = ~r_out_valid | i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign w_accept        = i_s_axis_tvalid & w_adv;

    ede_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_accept   (w_accept),
        .i_char     (i_s_axis_tdata),
        .i_has_char (i_s_axis_tuser[0]),
        .i_last     (i_s_axis_tlast),
        .i_sel      (w_m == '0),
        .o_tok      (w_tok[0])
    );

    for (genvar g = 1; g <= MAX_QUERY; g++) begin : g_cell
        t_char w_qchar;

        if (g - 1 < BYTES_PER_REG) begin : g_low
            assign w_qchar = r_qlo[CHAR_W*(g-1) +: CHAR_W];
        end else if (g - 1 < 2 * BYTES_PER_REG) begin : g_high
            assign w_qchar = r_qhi[CHAR_W*(g-1-BYTES_PER_REG) +: CHAR_W];
        end else begin : g_none
            assign w_qchar = '0;
        end

        ede_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_qchar (w_qchar),
            .i_init  ((g > 255) ? DIST_MAX : DIST_W'(g)),
            .i_sel   (w_m == POS_W'(g)),
            .i_tok   (w_tok[g-1]),
            .o_tok   (w_tok[g])
        );
    end

    // hold the result until taken; the row stalls behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_dist  <= '0;
            r_out_ovf   <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tok[MAX_QUERY].valid & w_tok[MAX_QUERY].last;
            r_out_dist  <= w_tok[MAX_QUERY].too_long ? DIST_MAX : w_tok[MAX_QUERY].result;
            r_out_ovf   <= w_tok[MAX_QUERY].too_long;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_dist;
    assign o_m_axis_tuser[0] = r_out_ovf;

endmodule

// ===== rtl/ede_checker.sv =====
// Port-level checks for the edit distance engine, bound to the top level.
// Depends on ede_pkg and edit_distance_engine.
`timescale 1ns / 1ps

module ede_checker
    import ede_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [7:0]        o_m_axis_tdata,
    input logic [0:0]        o_m_axis_tuser
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_overflow_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == DIST_MAX))
        else $error("overflow result without saturated distance");

    a_empty_out_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while no result is pending");

    a_cfg_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind edit_distance_engine ede_checker u_ede_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
